### rtl/core/rtcd_pkg.sv
// Types, codes and constants shared by the radio time-code decoder modules.
package rtcd_pkg;

	localparam int FRAME_W = 60;
	localparam int WIN_W = 12;
	localparam int WIDTH_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [5:0] POS_START = 6'd59;
	localparam logic [5:0] POS_RESTART = 6'd60;
	localparam logic [5:0] POS_FIRST_MARK = 6'd1;
	localparam logic [5:0] POS_HOUR_PARITY = 6'd24;
	localparam logic [5:0] POS_MIN_PARITY = 6'd23;
	localparam logic [5:0] POS_FRAME_END = 6'd0;

	// Last pin level seen; NONE until the first edge after reset.
	typedef enum logic [1:0] {
		LEVEL_LOW  = 2'd0,
		LEVEL_HIGH = 2'd1,
		LEVEL_NONE = 2'd2
	} level_t;

	typedef enum logic [1:0] {
		SYM_MARKER  = 2'd0,
		SYM_ONE     = 2'd1,
		SYM_ZERO    = 2'd2,
		SYM_UNKNOWN = 2'd3
	} sym_t;

	typedef enum logic [3:0] {
		EV_NONE        = 4'd0,
		EV_SYNC        = 4'd1,
		EV_MARK_DROP   = 4'd2,
		EV_POSMARK_ERR = 4'd3,
		EV_FIXZERO_ERR = 4'd4,
		EV_HOUR_ERR    = 4'd5,
		EV_HOUR_OK     = 4'd6,
		EV_MIN_ERR     = 4'd7,
		EV_MIN_OK      = 4'd8,
		EV_FRAME_DONE  = 4'd9
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MARKER_MIN = 3'd0,
		CFG_MARKER_MAX = 3'd1,
		CFG_ONE_MIN    = 3'd2,
		CFG_ONE_MAX    = 3'd3,
		CFG_ZERO_MIN   = 3'd4,
		CFG_ZERO_MAX   = 3'd5
	} cfg_idx_t;

	localparam logic [WIN_W-1:0] MARKER_MIN_RST = 12'd150;
	localparam logic [WIN_W-1:0] MARKER_MAX_RST = 12'd300;
	localparam logic [WIN_W-1:0] ONE_MIN_RST = 12'd300;
	localparam logic [WIN_W-1:0] ONE_MAX_RST = 12'd550;
	localparam logic [WIN_W-1:0] ZERO_MIN_RST = 12'd700;
	localparam logic [WIN_W-1:0] ZERO_MAX_RST = 12'd890;

	typedef struct packed {
		logic [WIN_W-1:0] marker_min_ms;
		logic [WIN_W-1:0] marker_max_ms;
		logic [WIN_W-1:0] one_min_ms;
		logic [WIN_W-1:0] one_max_ms;
		logic [WIN_W-1:0] zero_min_ms;
		logic [WIN_W-1:0] zero_max_ms;
	} cfg_t;

	typedef struct packed {
		logic        pin_level;
		logic [31:0] time_ms;
	} in_t;

	typedef struct packed {
		logic [15:0]        pulse_ms;
		logic [1:0]         symbol;
		logic [3:0]         event_res;
		logic               frame_done;
		logic               data_suspect;
		logic [7:0]         hour;
		logic [6:0]         minute;
		logic [8:0]         day_of_year;
		logic [7:0]         year;
		logic [2:0]         weekday;
		logic [FRAME_W-1:0] frame_bits;
	} out_t;

	// Pulse measurement handed from the edge stage to the frame tracker.
	typedef struct packed {
		logic               fall;
		logic [WIDTH_W-1:0] width;
		sym_t               sym;
	} pulse_t;

	typedef struct packed {
		ev_t                ev;
		logic               done;
		logic               suspect;
		logic [FRAME_W-1:0] bits;
	} frame_res_t;

endpackage

### rtl/core/rtcd_pulse.sv
// Edge filter, pulse width measurement and symbol classification.
module rtcd_pulse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  rtcd_pkg::in_t  item,
	input  rtcd_pkg::cfg_t cfg,
	output rtcd_pkg::pulse_t pulse
);
	import rtcd_pkg::*;

	level_t      last_level_q;
	logic [31:0] rise_q;
	logic [31:0] diff;
	logic [WIDTH_W-1:0] width;
	logic        changed;

	function automatic logic in_win(input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi,
			input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] lo_x;
		logic [WIDTH_W-1:0] hi_x;
		lo_x = {{(WIDTH_W-WIN_W){1'b0}}, lo};
		hi_x = {{(WIDTH_W-WIN_W){1'b0}}, hi};
		return (lo_x < w) && (w <= hi_x);
	endfunction

	assign changed = (last_level_q != level_t'({1'b0, item.pin_level}));
	assign diff = item.time_ms - rise_q;
	assign width = (|diff[31:WIDTH_W]) ? {WIDTH_W{1'b1}} : diff[WIDTH_W-1:0];

	always_comb begin
		pulse.fall = changed && !item.pin_level;
		pulse.width = width;
		// Windows are tried in order; the first match wins.
		if (in_win(cfg.marker_min_ms, cfg.marker_max_ms, width)) begin
			pulse.sym = SYM_MARKER;
		end else if (in_win(cfg.one_min_ms, cfg.one_max_ms, width)) begin
			pulse.sym = SYM_ONE;
		end else if (in_win(cfg.zero_min_ms, cfg.zero_max_ms, width)) begin
			pulse.sym = SYM_ZERO;
		end else begin
			pulse.sym = SYM_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= LEVEL_NONE;
			rise_q <= '0;
		end else if (go && changed) begin
			last_level_q <= level_t'({1'b0, item.pin_level});
			if (item.pin_level) begin
				rise_q <= item.time_ms;
			end
		end
	end

endmodule

### rtl/core/rtcd_frame.sv
// Sync search, frame assembly and frame checks.
module rtcd_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  rtcd_pkg::pulse_t     pulse,
	output rtcd_pkg::frame_res_t res
);
	import rtcd_pkg::*;

	sym_t               prev_q, prev_n;
	logic [5:0]         pos_q, pos_n;
	logic               sync_q, sync_n;
	logic               err_q, err_n;
	logic [FRAME_W-1:0] frame_q, frame_n;
	logic [5:0]         p;

	function automatic logic is_posmark(input logic [5:0] q);
		case (q)
			6'd51, 6'd41, 6'd31, 6'd21, 6'd11, 6'd1: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic is_fixzero(input logic [5:0] q);
		case (q)
			6'd56, 6'd50, 6'd49, 6'd46, 6'd40, 6'd39, 6'd36,
			6'd26, 6'd25, 6'd5, 6'd4, 6'd3, 6'd2: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	assign p = pos_q - 6'd1;

	always_comb begin
		prev_n = prev_q;
		pos_n = pos_q;
		sync_n = sync_q;
		err_n = err_q;
		frame_n = frame_q;
		res.ev = EV_NONE;
		res.done = 1'b0;
		res.suspect = 1'b0;
		res.bits = frame_q;
		if (pulse.sym != SYM_UNKNOWN) begin
			if (sync_q) begin
				if (prev_q == SYM_MARKER && pulse.sym == SYM_MARKER &&
						pos_q != POS_FIRST_MARK && pos_q != POS_RESTART) begin
					res.ev = EV_MARK_DROP;
				end else begin
					pos_n = p;
					// Positions above the frame are simply not stored.
					for (int i = 0; i < FRAME_W; i++) begin
						if (p == 6'(i)) begin
							frame_n[i] = (pulse.sym == SYM_ONE);
						end
					end
					res.bits = frame_n;
					if (is_posmark(p)) begin
						if (pulse.sym != SYM_MARKER) begin
							err_n = 1'b1;
							res.ev = EV_POSMARK_ERR;
						end
					end else if (is_fixzero(p)) begin
						if (pulse.sym != SYM_ZERO) begin
							sync_n = 1'b0;
							err_n = 1'b1;
							res.ev = EV_FIXZERO_ERR;
						end
					end else if (p == POS_HOUR_PARITY) begin
						if ((^frame_n[49:42]) != frame_n[24]) begin
							sync_n = 1'b0;
							res.ev = EV_HOUR_ERR;
						end else begin
							res.ev = EV_HOUR_OK;
						end
					end else if (p == POS_MIN_PARITY) begin
						if ((^frame_n[59:52]) != frame_n[23]) begin
							sync_n = 1'b0;
							res.ev = EV_MIN_ERR;
						end else begin
							res.ev = EV_MIN_OK;
						end
					end else if (p == POS_FRAME_END) begin
						res.ev = EV_FRAME_DONE;
						res.done = 1'b1;
						res.suspect = !sync_q || err_q;
						pos_n = POS_RESTART;
						frame_n = '0;
						sync_n = 1'b1;
						err_n = 1'b0;
					end
					prev_n = pulse.sym;
				end
			end else begin
				if (prev_q == SYM_MARKER && pulse.sym == SYM_MARKER) begin
					sync_n = 1'b1;
					err_n = 1'b0;
					pos_n = POS_RESTART;
					frame_n = '0;
					res.bits = '0;
					res.ev = EV_SYNC;
				end
				prev_n = pulse.sym;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= SYM_UNKNOWN;
			pos_q <= POS_START;
			sync_q <= 1'b0;
			err_q <= 1'b0;
			frame_q <= '0;
		end else if (go && pulse.fall) begin
			prev_q <= prev_n;
			pos_q <= pos_n;
			sync_q <= sync_n;
			err_q <= err_n;
			frame_q <= frame_n;
		end
	end

endmodule

### rtl/core/radio_time_code_decoder.sv
// Top level of the radio time-code decoder: input stage, windows, result register.
// An accepted word waits in the input stage; its result word is registered in the result register when it leaves.
// Throughput: one input word per cycle while the output side takes results.
// Edges that give no result (repeats, rising edges) pass through without waiting.
// Reset clears the edge and frame state and loads the default pulse windows.
module radio_time_code_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rtcd_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rtcd_pkg::out_t                    out_data,
	input  logic                              cfg_we,
	input  logic [rtcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtcd_pkg::WIN_W-1:0]        cfg_wdata
);
	import rtcd_pkg::*;

	in_t        item_s1;
	logic       valid_s1;
	cfg_t       cfg_q;
	pulse_t     pulse;
	frame_res_t fres;
	logic       advance;
	out_t       out_q;
	logic       out_valid_q;
	logic [FRAME_W-1:0] f;

	// The word in the input stage leaves when its result, if any, has a place to go.
	assign advance = valid_s1 && (!pulse.fall || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker_min_ms <= MARKER_MIN_RST;
			cfg_q.marker_max_ms <= MARKER_MAX_RST;
			cfg_q.one_min_ms <= ONE_MIN_RST;
			cfg_q.one_max_ms <= ONE_MAX_RST;
			cfg_q.zero_min_ms <= ZERO_MIN_RST;
			cfg_q.zero_max_ms <= ZERO_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MARKER_MIN: cfg_q.marker_min_ms <= cfg_wdata;
				CFG_MARKER_MAX: cfg_q.marker_max_ms <= cfg_wdata;
				CFG_ONE_MIN:    cfg_q.one_min_ms <= cfg_wdata;
				CFG_ONE_MAX:    cfg_q.one_max_ms <= cfg_wdata;
				CFG_ZERO_MIN:   cfg_q.zero_min_ms <= cfg_wdata;
				CFG_ZERO_MAX:   cfg_q.zero_max_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rtcd_pulse u_pulse (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (advance),
		.item  (item_s1),
		.cfg   (cfg_q),
		.pulse (pulse)
	);

	rtcd_frame u_frame (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (advance),
		.pulse (pulse),
		.res   (fres)
	);

	assign f = fres.bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && pulse.fall) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Digit fields are plain weighted sums of the BCD nibbles, not range checked.
	always_ff @(posedge clk) begin
		if (advance && pulse.fall) begin
			out_q.pulse_ms <= pulse.width;
			out_q.symbol <= pulse.sym;
			out_q.event_res <= fres.ev;
			out_q.frame_done <= fres.done;
			out_q.data_suspect <= fres.suspect;
			out_q.hour <= {4'd0, f[50:47]} * 8'd10 + {4'd0, f[45:42]};
			out_q.minute <= {4'd0, f[59:57]} * 7'd10 + {3'd0, f[55:52]};
			out_q.day_of_year <= {7'd0, f[38:37]} * 9'd100 + {5'd0, f[35:32]} * 9'd10
				+ {5'd0, f[30:27]};
			out_q.year <= {4'd0, f[19:16]} * 8'd10 + {4'd0, f[15:12]};
			out_q.weekday <= f[10:8];
			out_q.frame_bits <= f;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_done_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.event_res == EV_FRAME_DONE)
		else $error("frame done without frame done event");

	a_suspect_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.data_suspect |-> out_data.frame_done)
		else $error("suspect flag outside frame end");

	a_unknown_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.symbol == SYM_UNKNOWN |-> out_data.event_res == EV_NONE)
		else $error("unknown symbol raised an event");

	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == EV_SYNC |-> out_data.frame_bits == '0)
		else $error("sync event with non-empty frame");

endmodule
